// File: design/tqskm_pkg.sv
package tqskm_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  // Entry code: bits 5..4 suit minus one, bits 3..0 rank
  localparam int CODE_W = 6;

  // Operation codes
  typedef enum logic [1:0] {
    OP_APPEND      = 2'd0,
    OP_MOVE_ACROSS = 2'd1,
    OP_MOVE_BACK   = 2'd2,
    OP_NONE        = 2'd3
  } op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;
    logic scan;
    logic append;
    logic head;
    logic load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

// File: design/tqskm_ctrl.sv
module tqskm_ctrl
  import tqskm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_APPEND = 5'b00100,
    ST_HEAD   = 5'b01000,
    ST_LOAD   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence one item: scan, append, head read, result load
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        cmd.start = s_tvalid;
        if (s_tvalid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) state_next = ST_APPEND;
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_next = ST_HEAD;
      end
      ST_HEAD: begin
        cmd.head   = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/tqskm_dp.sv
module tqskm_dp
  import tqskm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [7:0]  s_tdata,
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata
);

  // Queue stores
  logic [CODE_W-1:0] north_mem [QUEUE_DEPTH];
  logic [CODE_W-1:0] south_mem [QUEUE_DEPTH];
  logic [CODE_W-1:0] north_rd;
  logic [CODE_W-1:0] south_rd;

  // Item registers
  op_t               op_q;
  logic              side_q;
  logic [CODE_W-1:0] code_q;
  logic              matched;
  logic              dropped_q;

  // Scan pipeline
  logic [FILL_W-1:0] rd_idx;
  logic              rd_vld;
  logic [ADDR_W-1:0] rd_pos;

  // Fill counts
  logic [FILL_W-1:0] fill_n;
  logic [FILL_W-1:0] fill_s;

  logic              is_move;
  logic [FILL_W-1:0] scan_fill;
  logic              scan_more;
  logic              scan_done;
  logic [CODE_W-1:0] scan_data;
  logic              hit;
  logic              shift_wr;
  logic              tgt_side;
  logic [FILL_W-1:0] tgt_fill;
  logic              tgt_full;
  logic              do_append;
  logic              app_wr;
  logic              north_we;
  logic              south_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [CODE_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              out_free;
  logic [2:0]        suit_in;
  logic [3:0]        rank_in;
  logic              nh_valid;
  logic              sh_valid;

  assign suit_in = s_tdata[2:0];
  assign rank_in = s_tdata[6:3];

  // Scan control
  assign is_move   = (op_q == OP_MOVE_ACROSS) || (op_q == OP_MOVE_BACK);
  assign scan_fill = side_q ? fill_s : fill_n;
  assign scan_more = cmd.scan && is_move && (rd_idx < scan_fill);
  assign scan_done = !(is_move && (rd_idx < scan_fill)) && !rd_vld;
  assign scan_data = side_q ? south_rd : north_rd;
  assign hit       = rd_vld && !matched && (scan_data == code_q);
  assign shift_wr  = cmd.scan && rd_vld && matched;

  // Append target
  assign tgt_side  = (op_q == OP_MOVE_ACROSS) ? ~side_q : side_q;
  assign tgt_fill  = tgt_side ? fill_s : fill_n;
  assign tgt_full  = (tgt_fill >= FILL_W'(QUEUE_DEPTH));
  assign do_append = cmd.append && (op_q != OP_NONE);
  assign app_wr    = do_append && !tgt_full;

  // Store write and read ports
  assign north_we = (shift_wr && !side_q) || (app_wr && !tgt_side);
  assign south_we = (shift_wr && side_q) || (app_wr && tgt_side);
  assign wr_addr  = shift_wr ? (rd_pos - ADDR_W'(1)) : tgt_fill[ADDR_W-1:0];
  assign wr_data  = shift_wr ? scan_data : code_q;
  assign rd_addr  = (cmd.head || cmd.load) ? '0 : rd_idx[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (north_we) north_mem[wr_addr] <= wr_data;
    north_rd <= north_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (south_we) south_mem[wr_addr] <= wr_data;
    south_rd <= south_mem[rd_addr];
  end

  // Latch item fields
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q   <= op_t'(s_tuser[1:0]);
      side_q <= s_tuser[2];
      code_q <= {suit_in[1:0] + 2'd3, rank_in};
    end
  end

  // Walk the owner's queue, then close up the gap behind a match
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      rd_vld    <= 1'b0;
      matched   <= 1'b0;
      dropped_q <= 1'b0;
    end else if (cmd.start) begin
      rd_idx    <= '0;
      rd_vld    <= 1'b0;
      matched   <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      if (cmd.scan) begin
        rd_vld <= scan_more;
        if (scan_more) begin
          rd_pos <= rd_idx[ADDR_W-1:0];
          rd_idx <= rd_idx + FILL_W'(1);
        end
        if (hit) matched <= 1'b1;
      end
      if (do_append && tgt_full) dropped_q <= 1'b1;
    end
  end

  // Fill counts: drop one at the end of a matching scan, add one per append that is not dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_n <= '0;
      fill_s <= '0;
    end else begin
      if (cmd.scan && scan_done && matched) begin
        if (side_q) fill_s <= fill_s - FILL_W'(1);
        else        fill_n <= fill_n - FILL_W'(1);
      end
      if (app_wr) begin
        if (tgt_side) fill_s <= fill_s + FILL_W'(1);
        else          fill_n <= fill_n + FILL_W'(1);
      end
    end
  end

  // Result register
  assign out_free = !m_tvalid || m_tready;
  assign nh_valid = (fill_n != '0);
  assign sh_valid = (fill_s != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && out_free) begin
      m_tdata[0]     <= matched;
      m_tdata[1]     <= dropped_q;
      m_tdata[2]     <= nh_valid;
      m_tdata[5:3]   <= nh_valid ? ({1'b0, north_rd[5:4]} + 3'd1) : 3'd0;
      m_tdata[9:6]   <= nh_valid ? north_rd[3:0] : 4'd0;
      m_tdata[10]    <= sh_valid;
      m_tdata[13:11] <= sh_valid ? ({1'b0, south_rd[5:4]} + 3'd1) : 3'd0;
      m_tdata[17:14] <= sh_valid ? south_rd[3:0] : 4'd0;
      m_tdata[24:18] <= 7'(fill_n);
      m_tdata[31:25] <= 7'(fill_s);
    end
  end

  assign status.scan_done = scan_done;
  assign status.out_free  = out_free;

endmodule

// File: design/two_queue_store_keyed_move_core.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata {rank, suit}, s_tuser {owner, operation}
// m_*       out  m_tvalid/m_tready  m_tdata result: flags, both heads, both counts
//
// One item at a time. An append, an unused code or a move on an empty queue
// reads no entries; a move on a non-empty queue walks the owner's queue, as the
// scan reads one stored entry per cycle through the store's single read port,
// waits out the read latency after the last entry and closes the gap behind a
// match as it goes. The result register frees the scan from the output side; a
// stalled result holds the block in its last step until taken.
// rst (synchronous) empties both queues; the stores need no clearing pass.
module two_queue_store_keyed_move_core
  import tqskm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [2:0] suit, [6:3] rank, [7] zero
  input  logic [2:0]  s_tuser,   // [1:0] operation, [2] owner
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [0] found, [1] dropped, [2] north_head_valid,
                                 // [5:3] north_head_suit, [9:6] north_head_rank,
                                 // [10] south_head_valid, [13:11] south_head_suit,
                                 // [17:14] south_head_rank, [24:18] north_count,
                                 // [31:25] south_count
);

  cmd_t    cmd;
  status_t status;

  tqskm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tqskm_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // At most one command step at a time
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.scan, cmd.append, cmd.head, cmd.load}))
    else $error("controller issued overlapping commands");

  // No new item while one is being worked on
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken twice for one item");

  // A load into a free result register presents the result
  assert property (@(posedge clk) disable iff (rst)
    (cmd.load && status.out_free) |=> m_tvalid)
    else $error("result load lost");

endmodule

// File: tb/queue_pair_checker.sv
module queue_pair_checker
  import tqskm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [2:0] suit, [6:3] rank, [7] zero
  input  logic [2:0]  s_tuser,   // [1:0] operation, [2] owner
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [0] found, [1] dropped, [2] north_head_valid,
                                 // [5:3] north_head_suit, [9:6] north_head_rank,
                                 // [10] south_head_valid, [13:11] south_head_suit,
                                 // [17:14] south_head_rank, [24:18] north_count,
                                 // [31:25] south_count
  output int          mismatches,
  output int          outstanding
);

  // Result layout, lowest field last
  typedef struct packed {
    logic [6:0] south_count;
    logic [6:0] north_count;
    logic [3:0] south_rank;
    logic [2:0] south_suit;
    logic       south_valid;
    logic [3:0] north_rank;
    logic [2:0] north_suit;
    logic       north_valid;
    logic       dropped;
    logic       found;
  } outcome_t;

  // Shadow queues: index 0 north, 1 south
  logic [CODE_W-1:0] pile [2][QUEUE_DEPTH];
  int                fill [2];
  outcome_t          due [$];

  // Remove the first entry equal to key; tell whether one went
  function automatic logic take_first(logic side, logic [CODE_W-1:0] key);
    int i;
    int at;
    at = -1;
    for (i = 0; i < fill[side]; i++)
      if (at < 0 && pile[side][i] == key) at = i;
    if (at < 0) return 1'b0;
    for (i = at; i + 1 < fill[side]; i++)
      pile[side][i] = pile[side][i + 1];
    fill[side]--;
    return 1'b1;
  endfunction

  // Append key at the tail; tell whether the queue was full
  function automatic logic add_tail(logic side, logic [CODE_W-1:0] key);
    if (fill[side] >= QUEUE_DEPTH) return 1'b1;
    pile[side][fill[side]] = key;
    fill[side]++;
    return 1'b0;
  endfunction

  // Apply one operation to the shadow queues and build its result
  function automatic outcome_t play(op_t op, logic side, logic [2:0] suit,
                                    logic [3:0] rank);
    outcome_t res;
    logic [CODE_W-1:0] key;
    res = '0;
    key = {2'(suit[1:0] + 2'd3), rank};
    case (op)
      OP_APPEND: res.dropped = add_tail(side, key);
      OP_MOVE_ACROSS: begin
        res.found   = take_first(side, key);
        res.dropped = add_tail(~side, key);
      end
      OP_MOVE_BACK: begin
        res.found   = take_first(side, key);
        res.dropped = add_tail(side, key);
      end
      default: ;
    endcase
    if (fill[0] != 0) begin
      res.north_valid = 1'b1;
      res.north_suit  = {1'b0, pile[0][0][5:4]} + 3'd1;
      res.north_rank  = pile[0][0][3:0];
    end
    if (fill[1] != 0) begin
      res.south_valid = 1'b1;
      res.south_suit  = {1'b0, pile[1][0][5:4]} + 3'd1;
      res.south_rank  = pile[1][0][3:0];
    end
    res.north_count = 7'(fill[0]);
    res.south_count = 7'(fill[1]);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [6:0] got, logic [6:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task automatic compare_result(outcome_t got, outcome_t want);
    check_field("found", 7'(got.found), 7'(want.found));
    check_field("dropped", 7'(got.dropped), 7'(want.dropped));
    check_field("north_head_valid", 7'(got.north_valid), 7'(want.north_valid));
    check_field("north_head_suit", 7'(got.north_suit), 7'(want.north_suit));
    check_field("north_head_rank", 7'(got.north_rank), 7'(want.north_rank));
    check_field("south_head_valid", 7'(got.south_valid), 7'(want.south_valid));
    check_field("south_head_suit", 7'(got.south_suit), 7'(want.south_suit));
    check_field("south_head_rank", 7'(got.south_rank), 7'(want.south_rank));
    check_field("north_count", got.north_count, want.north_count);
    check_field("south_count", got.south_count, want.south_count);
  endtask

  // Match results first, then predict the item taken on this edge
  always @(posedge clk) begin
    if (rst) begin
      fill[0]    = 0;
      fill[1]    = 0;
      mismatches = 0;
      due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (due.size() == 0)
          report_mismatch($sformatf("result %h with nothing expected", m_tdata));
        else
          compare_result(outcome_t'(m_tdata), due.pop_front());
      end
      if (s_tvalid && s_tready)
        due.push_back(play(op_t'(s_tuser[1:0]), s_tuser[2], s_tdata[2:0],
                           s_tdata[6:3]));
    end
    outstanding <= due.size();
  end

endmodule

// File: tb/tb_top.sv
module tb_top;
  import tqskm_pkg::*;

  localparam int IDLE_LIMIT      = 4000;
  localparam int ITEMS_PER_PHASE = 450;
  localparam int SETTLE_CYCLES   = 80;

  typedef enum int {
    SCENE_FILL,
    SCENE_DRAIN_NORTH,
    SCENE_DRAIN_SOUTH,
    SCENE_SHUFFLE,
    SCENE_NOISE
  } scene_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [2:0] suit, [6:3] rank, [7] zero
  logic [2:0]  s_tuser;   // [1:0] operation, [2] owner
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // flags, both heads, both counts
  int          mismatches;
  int          outstanding;
  int          send_gap_pct = 0;
  int          take_gap_pct = 0;
  int          quiet_cycles = 0;
  int          counted = 0;

  two_queue_store_keyed_move_core u_top (.*);
  queue_pair_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Randomly hold off the result channel
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= take_gap_pct);
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one item after a random gap; return at the edge that takes it
  task automatic offer(op_t op, logic owner, logic [2:0] suit, logic [3:0] rank);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, rank, suit};
    s_tuser  <= {owner, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op != OP_NONE) counted++;
  endtask

  // Hold the sender until every predicted result has been taken
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Mostly a small key set so that moves find their entries
  task automatic pick_key(bit wide, output logic [2:0] suit, output logic [3:0] rank);
    if (wide) begin
      suit = 3'($urandom_range(1, 4));
      rank = 4'($urandom_range(1, 13));
    end else begin
      suit = 3'($urandom_range(1, 2));
      rank = 4'($urandom_range(1, 3));
    end
  endtask

  task automatic random_item(scene_t scene);
    int         roll;
    op_t        op;
    logic       owner;
    logic [2:0] suit;
    logic [3:0] rank;
    roll  = $urandom_range(0, 99);
    owner = 1'($urandom_range(0, 1));
    pick_key($urandom_range(0, 99) < 15, suit, rank);
    case (scene)
      SCENE_FILL: begin
        if (roll < 70) op = OP_APPEND;
        else if (roll < 85) op = OP_MOVE_ACROSS;
        else if (roll < 97) op = OP_MOVE_BACK;
        else op = OP_NONE;
      end
      SCENE_DRAIN_NORTH, SCENE_DRAIN_SOUTH: begin
        // Move across into a full queue shrinks the source
        if (roll < 85) op = OP_MOVE_ACROSS;
        else if (roll < 95) op = OP_MOVE_BACK;
        else op = OP_APPEND;
        if ($urandom_range(0, 99) < 85) owner = (scene == SCENE_DRAIN_SOUTH);
      end
      SCENE_SHUFFLE: begin
        if (roll < 55) op = OP_MOVE_BACK;
        else if (roll < 85) op = OP_MOVE_ACROSS;
        else op = OP_APPEND;
      end
      default: begin
        op   = op_t'($urandom_range(0, 3));
        suit = 3'($urandom_range(0, 7));
        rank = 4'($urandom_range(0, 15));
      end
    endcase
    offer(op, owner, suit, rank);
  endtask

  // Run scenes of random length until the phase quota is sent
  task automatic run_phase(int send_pct, int take_pct);
    int     stop;
    int     span;
    int     k;
    int     roll;
    scene_t scene;
    send_gap_pct = send_pct;
    take_gap_pct = take_pct;
    stop = counted + ITEMS_PER_PHASE;
    while (counted < stop) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) scene = SCENE_FILL;
      else if (roll < 47) scene = SCENE_DRAIN_NORTH;
      else if (roll < 69) scene = SCENE_DRAIN_SOUTH;
      else if (roll < 90) scene = SCENE_SHUFFLE;
      else scene = SCENE_NOISE;
      span = $urandom_range(30, 120);
      for (k = 0; k < span && counted < stop; k++) random_item(scene);
      if ($urandom_range(0, 3) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    send_gap_pct = 20;
    take_gap_pct = 59;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Moves on empty queues still append
    offer(OP_MOVE_ACROSS, 1'b0, 3'd2, 4'd5);
    // Sole entry taken and put back: tail follows the removal
    offer(OP_MOVE_BACK, 1'b1, 3'd2, 4'd5);
    offer(OP_MOVE_BACK, 1'b0, 3'd3, 4'd7);
    // Field extremes, out-of-range suits wrap
    offer(OP_APPEND, 1'b0, 3'd1, 4'd1);
    offer(OP_APPEND, 1'b0, 3'd4, 4'd13);
    offer(OP_APPEND, 1'b1, 3'd0, 4'd0);
    offer(OP_APPEND, 1'b1, 3'd7, 4'd15);
    // Unused code leaves both queues alone
    offer(OP_NONE, 1'b0, 3'd5, 4'd9);
    offer(OP_NONE, 1'b1, 3'd7, 4'd15);
    // Match in the middle, at the head, through a wrapped suit
    offer(OP_MOVE_ACROSS, 1'b0, 3'd1, 4'd1);
    offer(OP_MOVE_BACK, 1'b1, 3'd4, 4'd0);
    offer(OP_MOVE_ACROSS, 1'b1, 3'd6, 4'd5);
    offer(OP_MOVE_BACK, 1'b0, 3'd3, 4'd7);
    offer(OP_MOVE_ACROSS, 1'b0, 3'd4, 4'd13);
    // Miss on a non-empty queue
    offer(OP_MOVE_ACROSS, 1'b1, 3'd2, 4'd9);
    offer(OP_MOVE_BACK, 1'b0, 3'd5, 4'd8);
    drain_results();

    run_phase(20, 59);
    run_phase(59, 20);
    run_phase(0, 0);

    // Let any late or stray result show up
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
